### rtl/hba_pkg.sv
// Shared constants, codes and types of the heap bank allocator.
`timescale 1ns / 1ps
`default_nettype none

package hba_pkg;

  localparam int DATA_W         = 32;
  localparam int CODE_W         = 2;
  localparam int BANK_COUNT_DEF = 128;
  localparam int BANK_BYTES_DEF = 64;
  localparam int LANES          = 4;
  localparam int CHUNK_BITS     = 32;

  localparam logic [DATA_W-1:0] HEAP_BASE_RST = 32'h0000_B700;
  localparam logic [DATA_W-1:0] SEXT_BYTE     = 32'hFFFF_FF00;
  localparam logic [DATA_W-1:0] SEXT_HALF     = 32'hFFFF_0000;

  typedef enum logic [CODE_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_STORE = 2'd3
  } req_t;

  typedef enum logic [CODE_W-1:0] {
    AW_BYTE = 2'd0,
    AW_HALF = 2'd1,
    AW_WORD = 2'd2
  } width_t;

  typedef enum logic [CODE_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

endpackage

`default_nettype wire

### rtl/hba_req_if.sv
// Request channel: valid/ready handshake with the request word.
`timescale 1ns / 1ps
`default_nettype none

interface hba_req_if;
  import hba_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] req_type;
  logic [DATA_W-1:0] alloc_bytes;
  logic [DATA_W-1:0] address;
  logic [CODE_W-1:0] access_width;
  logic              sign_extend;
  logic [DATA_W-1:0] store_data;

  modport source (
    output valid, req_type, alloc_bytes, address, access_width, sign_extend, store_data,
    input  ready
  );

  modport sink (
    input  valid, req_type, alloc_bytes, address, access_width, sign_extend, store_data,
    output ready
  );
endinterface

`default_nettype wire

### rtl/hba_rsp_if.sv
// Response channel: valid/ready handshake with the response word.
`timescale 1ns / 1ps
`default_nettype none

interface hba_rsp_if;
  import hba_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic [CODE_W-1:0] status;

  modport source (
    output valid, read_value, status,
    input  ready
  );

  modport sink (
    input  valid, read_value, status,
    output ready
  );
endinterface

`default_nettype wire

### rtl/hba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hba_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/heap_bank_allocator.sv
// Top level: first-fit bank allocator with byte heap, load and store.
//
//  channel   dir  handshake               word
//  in_req    in   valid/ready             req_type, alloc_bytes, address,
//                                         access_width, sign_extend, store_data
//  out_rsp   out  valid/ready             read_value, status
//  cfg_*     in   cfg_wr_en               cfg_wr_data -> heap_base
//
//  One request at a time. A store goes from dispatch to finish; free and load pass
//  through a read state between them; alloc passes through the shift-and-merge
//  free-run build, the scan of the free-run map by 32-bank chunks, and the run marking.
//  After reset a clearing pass over every row zeroes the byte and run memories;
//  no request is taken meanwhile.
//  A held response does not block the next request; it waits only to hand off its own.
`timescale 1ns / 1ps
`default_nettype none

module heap_bank_allocator #(
  parameter int BANK_COUNT = hba_pkg::BANK_COUNT_DEF,
  parameter int BANK_BYTES = hba_pkg::BANK_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  hba_req_if.sink                         in_req,
  hba_rsp_if.source                       out_rsp,
  input  wire logic                       cfg_wr_en,
  input  wire logic [hba_pkg::DATA_W-1:0] cfg_wr_data
);
  import hba_pkg::*;

  localparam int HEAP_SIZE = BANK_COUNT * BANK_BYTES;
  localparam int BB_LOG    = $clog2(BANK_BYTES);
  localparam int BANK_W    = $clog2(BANK_COUNT);
  localparam int NEED_W    = $clog2(BANK_COUNT + 1);
  localparam int META_W    = NEED_W + 1;
  localparam int STEP_W    = $clog2(NEED_W);
  localparam int ROWS      = HEAP_SIZE / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CHUNKS    = (BANK_COUNT + CHUNK_BITS) / CHUNK_BITS;
  localparam int SCAN_W    = CHUNKS * CHUNK_BITS;
  localparam int CHK_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int ENC_W     = $clog2(CHUNK_BITS);
  localparam int E_W       = CHK_W + ENC_W;
  localparam logic [DATA_W-1:0] HEAP_LIM = DATA_W'(HEAP_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FREE, S_LOAD, S_BUILD, S_SEARCH, S_ALLOC, S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [ROW_W-1:0]      clr_r, clr_nxt;
  logic [DATA_W-1:0]     heap_base_r, heap_base_nxt;
  logic [BANK_COUNT-1:0] in_use_r, in_use_nxt;
  logic [CODE_W-1:0]     req_type_r, req_type_nxt;
  logic [DATA_W-1:0]     size_r, size_nxt;
  logic [DATA_W-1:0]     off_r, off_nxt;
  logic [CODE_W-1:0]     aw_r, aw_nxt;
  logic                  sext_r, sext_nxt;
  logic [DATA_W-1:0]     data_r, data_nxt;
  logic [NEED_W-1:0]     need_r, need_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [BANK_COUNT-1:0] fit_r, fit_nxt;
  logic [BANK_COUNT:0]   end_r, end_nxt;
  logic [SCAN_W-1:0]     scan_r, scan_nxt;
  logic [CHK_W-1:0]      chunk_r, chunk_nxt;
  logic [BANK_W-1:0]     start_r, start_nxt;
  logic [DATA_W-1:0]     res_val_r, res_val_nxt;
  logic [CODE_W-1:0]     res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_val_r, out_val_nxt;
  logic [CODE_W-1:0]     out_st_r, out_st_nxt;

  logic              meta_we;
  logic [BANK_W-1:0] meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;

  logic             lane_we    [LANES];
  logic [ROW_W-1:0] lane_waddr [LANES];
  logic [7:0]       lane_wdata [LANES];
  logic [ROW_W-1:0] lane_raddr [LANES];
  logic [7:0]       lane_rdata [LANES];

  logic [BANK_W-1:0] off_bank;
  logic [2:0]        n_bytes;
  logic              aw_ok;
  logic              acc_ok;
  logic [DATA_W:0]   need_sum;
  logic [NEED_W-1:0] need_raw;
  logic [NEED_W-1:0] sh_amt;
  logic [CHUNK_BITS-1:0] low_chunk;
  logic [ENC_W-1:0]  enc;
  logic [E_W-1:0]    end_pos;
  logic [NEED_W:0]   rng_lo;
  logic [NEED_W:0]   rng_hi;
  logic [DATA_W-1:0] load_val;
  logic [1:0]        lane_k    [LANES];
  logic [1:0]        byte_lane [LANES];

  assign off_bank = off_r[BB_LOG +: BANK_W];

  hba_ram #(.WIDTH(META_W), .DEPTH(BANK_COUNT)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (off_bank),
    .rdata (meta_rdata)
  );

  for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
    assign lane_k[gl]     = 2'(gl) - off_r[1:0];
    assign byte_lane[gl]  = off_r[1:0] + 2'(gl);
    assign lane_raddr[gl] = off_r[2 +: ROW_W] + ROW_W'(2'(gl) < off_r[1:0]);

    hba_ram #(.WIDTH(8), .DEPTH(ROWS)) u_byte_ram (
      .clk   (clk),
      .we    (lane_we[gl]),
      .waddr (lane_waddr[gl]),
      .wdata (lane_wdata[gl]),
      .raddr (lane_raddr[gl]),
      .rdata (lane_rdata[gl])
    );
  end

  always_comb begin
    aw_ok   = 1'b1;
    n_bytes = 3'd4;
    case (aw_r)
      AW_BYTE: n_bytes = 3'd1;
      AW_HALF: n_bytes = 3'd2;
      AW_WORD: n_bytes = 3'd4;
      default: aw_ok = 1'b0;
    endcase
  end

  assign acc_ok = aw_ok && (({1'b0, off_r} + (DATA_W+1)'(n_bytes)) <= {1'b0, HEAP_LIM})
                  && in_use_r[off_bank];

  assign need_sum = {1'b0, size_r} + (DATA_W+1)'(BANK_BYTES - 1);
  assign need_raw = NEED_W'(need_sum >> BB_LOG);
  assign sh_amt   = NEED_W'(1) << step_r;

  assign low_chunk = scan_r[CHUNK_BITS-1:0];
  always_comb begin
    enc = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (low_chunk[i]) begin
        enc = ENC_W'(i);
      end
    end
  end
  assign end_pos = {chunk_r, enc};

  always_comb begin
    load_val = '0;
    for (int k = 0; k < LANES; k++) begin
      if (3'(k) < n_bytes) begin
        load_val[8*k +: 8] = lane_rdata[byte_lane[k]];
      end
    end
    if (sext_r && (n_bytes == 3'd1) && load_val[7]) begin
      load_val = load_val | SEXT_BYTE;
    end
    if (sext_r && (n_bytes == 3'd2) && load_val[15]) begin
      load_val = load_val | SEXT_HALF;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    heap_base_nxt = heap_base_r;
    in_use_nxt    = in_use_r;
    req_type_nxt  = req_type_r;
    size_nxt      = size_r;
    off_nxt       = off_r;
    aw_nxt        = aw_r;
    sext_nxt      = sext_r;
    data_nxt      = data_r;
    need_nxt      = need_r;
    step_nxt      = step_r;
    fit_nxt       = fit_r;
    end_nxt       = end_r;
    scan_nxt      = scan_r;
    chunk_nxt     = chunk_r;
    start_nxt     = start_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    meta_we       = 1'b0;
    meta_waddr    = start_r;
    meta_wdata    = '0;
    rng_lo        = '0;
    rng_hi        = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_we[l]    = 1'b0;
      lane_waddr[l] = lane_raddr[l];
      lane_wdata[l] = data_r[{lane_k[l], 3'b000} +: 8];
    end

    if (cfg_wr_en) begin
      heap_base_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        for (int l = 0; l < LANES; l++) begin
          lane_we[l]    = 1'b1;
          lane_waddr[l] = clr_r;
          lane_wdata[l] = '0;
        end
        meta_we    = (32'(clr_r) < BANK_COUNT);
        meta_waddr = clr_r[BANK_W-1:0];
        clr_nxt    = clr_r + ROW_W'(1);
        if (clr_r == ROW_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_req.valid) begin
          req_type_nxt = in_req.req_type;
          size_nxt     = in_req.alloc_bytes;
          off_nxt      = in_req.address - heap_base_r;
          aw_nxt       = in_req.access_width;
          sext_nxt     = in_req.sign_extend;
          data_nxt     = in_req.store_data;
          state_nxt    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_val_nxt = '0;
        res_st_nxt  = ST_OK;
        state_nxt   = S_FINISH;
        case (req_type_r)
          REQ_ALLOC: begin
            if (size_r > HEAP_LIM) begin
              res_st_nxt = ST_NOSPACE;
            end else begin
              need_nxt  = (need_raw == '0) ? NEED_W'(1) : need_raw;
              fit_nxt   = ~in_use_r;
              end_nxt   = '1;
              step_nxt  = '0;
              state_nxt = S_BUILD;
            end
          end
          REQ_FREE: begin
            if (off_r >= HEAP_LIM) begin
              res_st_nxt = ST_ILLEGAL;
            end else begin
              state_nxt = S_FREE;
            end
          end
          REQ_LOAD: begin
            if (!acc_ok) begin
              res_st_nxt = ST_ILLEGAL;
            end else begin
              state_nxt = S_LOAD;
            end
          end
          REQ_STORE: begin
            if (!acc_ok) begin
              res_st_nxt = ST_ILLEGAL;
            end else begin
              for (int l = 0; l < LANES; l++) begin
                lane_we[l] = (3'(lane_k[l]) < n_bytes);
              end
            end
          end
          default: res_st_nxt = ST_ILLEGAL;
        endcase
      end

      S_FREE: begin
        state_nxt = S_FINISH;
        if (meta_rdata[NEED_W] && in_use_r[off_bank]) begin
          rng_lo     = (NEED_W+1)'(off_bank);
          rng_hi     = rng_lo + (NEED_W+1)'(meta_rdata[NEED_W-1:0]);
          for (int i = 0; i < BANK_COUNT; i++) begin
            if (((NEED_W+1)'(i) >= rng_lo) && ((NEED_W+1)'(i) < rng_hi)) begin
              in_use_nxt[i] = 1'b0;
            end
          end
          meta_we    = 1'b1;
          meta_waddr = off_bank;
          meta_wdata = '0;
        end else begin
          res_st_nxt = ST_ILLEGAL;
        end
      end

      S_LOAD: begin
        res_val_nxt = load_val;
        state_nxt   = S_FINISH;
      end

      S_BUILD: begin
        if (need_r[step_r]) begin
          end_nxt = {1'b0, end_r[BANK_COUNT-1:0] & fit_r} << sh_amt;
        end
        fit_nxt  = fit_r & (fit_r >> sh_amt);
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NEED_W - 1)) begin
          scan_nxt  = SCAN_W'(need_r[step_r] ? ({1'b0, end_r[BANK_COUNT-1:0] & fit_r}
                                                << sh_amt) : end_r);
          chunk_nxt = '0;
          state_nxt = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (|low_chunk) begin
          start_nxt = BANK_W'(end_pos - E_W'(need_r));
          state_nxt = S_ALLOC;
        end else if (chunk_r == CHK_W'(CHUNKS - 1)) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt  = S_FINISH;
        end else begin
          scan_nxt  = scan_r >> CHUNK_BITS;
          chunk_nxt = chunk_r + CHK_W'(1);
        end
      end

      S_ALLOC: begin
        rng_lo = (NEED_W+1)'(start_r);
        rng_hi = rng_lo + (NEED_W+1)'(need_r);
        for (int i = 0; i < BANK_COUNT; i++) begin
          if (((NEED_W+1)'(i) >= rng_lo) && ((NEED_W+1)'(i) < rng_hi)) begin
            in_use_nxt[i] = 1'b1;
          end
        end
        meta_we     = 1'b1;
        meta_waddr  = start_r;
        meta_wdata  = {1'b1, need_r};
        res_val_nxt = heap_base_r + (DATA_W'(start_r) << BB_LOG);
        state_nxt   = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      heap_base_r <= HEAP_BASE_RST;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      heap_base_r <= heap_base_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_type_r <= req_type_nxt;
    size_r     <= size_nxt;
    off_r      <= off_nxt;
    aw_r       <= aw_nxt;
    sext_r     <= sext_nxt;
    data_r     <= data_nxt;
    need_r     <= need_nxt;
    step_r     <= step_nxt;
    fit_r      <= fit_nxt;
    end_r      <= end_nxt;
    scan_r     <= scan_nxt;
    chunk_r    <= chunk_nxt;
    start_r    <= start_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.read_value = out_val_r;
  assign out_rsp.status     = out_st_r;

endmodule

`default_nettype wire

### sim/heap_bank_checker.sv
// Checker for the heap bank allocator: predicts each response word and compares it.
`timescale 1ns / 1ps

module heap_bank_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  hba_req_if                         req_mon,
  hba_rsp_if                         rsp_mon,
  input  logic                       cfg_wr_en,
  input  logic [hba_pkg::DATA_W-1:0] cfg_wr_data,
  output int                         fails,
  output int                         pending,
  output int                         checked
);
  import hba_pkg::*;

  localparam int BANK_N     = BANK_COUNT_DEF;
  localparam int BANK_SZ    = BANK_BYTES_DEF;
  localparam int HEAP_BYTES = BANK_N * BANK_SZ;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
  } heap_answer_t;

  logic [DATA_W-1:0] base_addr;
  logic              bank_busy [BANK_N];
  logic              bank_head [BANK_N];
  logic [7:0]        bank_span [BANK_N];
  logic [7:0]        heap_mem  [HEAP_BYTES];
  heap_answer_t      answers_due [$];

  task automatic model_heap_request(input req_t kind, input logic [DATA_W-1:0] size,
                                    input logic [DATA_W-1:0] addr, input logic [1:0] aw,
                                    input logic sx, input logic [DATA_W-1:0] wdata,
                                    output heap_answer_t ans);
    logic [32:0]       need;
    logic [32:0]       last;
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] v;
    logic              fits;
    int                start, k, len, bank, nbytes;
    ans.value  = '0;
    ans.status = ST_OK;
    off = addr - base_addr;
    case (kind)
      REQ_ALLOC: begin
        need = ({1'b0, size} + 33'(BANK_SZ - 1)) / 33'(BANK_SZ);
        if (need == 33'd0) need = 33'd1;
        ans.status = ST_NOSPACE;
        if (need <= 33'(BANK_N)) begin
          len = int'(need);
          for (start = 0; start + len <= BANK_N; start++) begin
            fits = 1'b1;
            for (k = 0; k < len; k++)
              if (bank_busy[start + k]) fits = 1'b0;
            if (fits) begin
              for (k = 0; k < len; k++) bank_busy[start + k] = 1'b1;
              bank_head[start] = 1'b1;
              bank_span[start] = 8'(len);
              ans.value  = base_addr + 32'(start * BANK_SZ);
              ans.status = ST_OK;
              break;
            end
          end
        end
      end
      REQ_FREE: begin
        ans.status = ST_ILLEGAL;
        if (off < 32'(HEAP_BYTES)) begin
          bank = int'(off) / BANK_SZ;
          if (bank_head[bank] && bank_busy[bank]) begin
            len = int'(bank_span[bank]);
            for (k = 0; k < len && bank + k < BANK_N; k++) begin
              bank_busy[bank + k] = 1'b0;
              bank_head[bank + k] = 1'b0;
              bank_span[bank + k] = '0;
            end
            ans.status = ST_OK;
          end
        end
      end
      default: begin
        nbytes = (aw == AW_BYTE) ? 1 : (aw == AW_HALF) ? 2 : 4;
        last = {1'b0, off} + 33'(nbytes);
        ans.status = ST_ILLEGAL;
        if ((aw == AW_BYTE || aw == AW_HALF || aw == AW_WORD) && last <= 33'(HEAP_BYTES)) begin
          if (bank_busy[int'(off) / BANK_SZ]) begin
            ans.status = ST_OK;
            if (kind == REQ_LOAD) begin
              v = '0;
              for (k = 0; k < nbytes; k++) v |= 32'(heap_mem[off + k]) << (8 * k);
              if (sx && nbytes == 1 && v[7]) v |= SEXT_BYTE;
              if (sx && nbytes == 2 && v[15]) v |= SEXT_HALF;
              ans.value = v;
            end else begin
              for (k = 0; k < nbytes; k++) heap_mem[off + k] = wdata[8*k +: 8];
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    heap_answer_t want;
    heap_answer_t got_pred;
    if (!rst_n) begin
      base_addr = HEAP_BASE_RST;
      for (int i = 0; i < BANK_N; i++) begin
        bank_busy[i] = 1'b0;
        bank_head[i] = 1'b0;
        bank_span[i] = '0;
      end
      for (int i = 0; i < HEAP_BYTES; i++) heap_mem[i] = '0;
      answers_due.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_wr_en) base_addr = cfg_wr_data;
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: response word with none expected: read_value %h status %0d",
                   $time, rsp_mon.read_value, rsp_mon.status);
          fails++;
        end else begin
          want = answers_due.pop_front();
          checked++;
          if (rsp_mon.read_value !== want.value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.value, rsp_mon.read_value);
            fails++;
          end
          if (rsp_mon.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp_mon.status);
            fails++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        model_heap_request(req_t'(req_mon.req_type), req_mon.alloc_bytes, req_mon.address,
                           req_mon.access_width, req_mon.sign_extend, req_mon.store_data,
                           got_pred);
        answers_due.push_back(got_pred);
      end
    end
    pending = answers_due.size();
  end

endmodule

### sim/heap_bank_allocator_tb.sv
// Testbench top: drives request words and heap base writes, gives the verdict.
`timescale 1ns / 1ps

module heap_bank_allocator_tb;
  import hba_pkg::*;

  localparam int BANK_N     = BANK_COUNT_DEF;
  localparam int BANK_SZ    = BANK_BYTES_DEF;
  localparam int HEAP_BYTES = BANK_N * BANK_SZ;
  localparam int PHASE_OPS  = 370;
  localparam int LIMIT      = 400000;
  localparam logic [1:0] AW_BAD = 2'd3;

  typedef struct {
    logic [DATA_W-1:0] off;
    int                banks;
  } live_run_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;
  logic [DATA_W-1:0] heap_base = HEAP_BASE_RST;
  bit                calm = 1'b0;
  int                fails, pending, checked;
  int                cycles = 0;
  int                bases_used = 1;
  int                sent_by_kind [4];
  int                nospace_seen = 0;
  int                illegal_seen = 0;
  int                span_due [$];
  live_run_t         live_runs [$];

  hba_req_if req_ch();
  hba_rsp_if rsp_ch();

  heap_bank_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_ch),
    .out_rsp    (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  heap_bank_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fails      (fails),
    .pending    (pending),
    .checked    (checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, pending);
      $display("[heap_bank_allocator] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready = calm || ($urandom_range(99) >= 30);
  end

  // track successful allocs so later words can target live runs
  always @(posedge clk) begin
    int span;
    if (rst_n && rsp_ch.valid && rsp_ch.ready && span_due.size() > 0) begin
      span = span_due.pop_front();
      if (rsp_ch.status == ST_NOSPACE) nospace_seen++;
      if (rsp_ch.status == ST_ILLEGAL) illegal_seen++;
      if (span > 0 && rsp_ch.status == ST_OK)
        live_runs.push_back('{rsp_ch.read_value - heap_base, span});
    end
  end

  function automatic int banks_for(logic [DATA_W-1:0] size);
    logic [32:0] n;
    n = ({1'b0, size} + 33'(BANK_SZ - 1)) / 33'(BANK_SZ);
    if (n == 33'd0) return 1;
    return (n > 33'(BANK_N)) ? 0 : int'(n);
  endfunction

  function automatic logic [DATA_W-1:0] random_size();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return $urandom_range(1, 256);
    if (pick < 8) return $urandom_range(257, 1024);
    if (pick < 9) return $urandom_range(0, HEAP_BYTES);
    return $urandom;
  endfunction

  task automatic send_heap_op(input req_t kind, input logic [DATA_W-1:0] size,
                              input logic [DATA_W-1:0] addr, input logic [1:0] aw,
                              input logic sx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 30) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.req_type     = kind;
    req_ch.alloc_bytes  = size;
    req_ch.address      = addr;
    req_ch.access_width = aw;
    req_ch.sign_extend  = sx;
    req_ch.store_data   = data;
    do @(posedge clk); while (!req_ch.ready);
    sent_by_kind[kind]++;
    span_due.push_back(kind == REQ_ALLOC ? banks_for(size) : 0);
  endtask

  task automatic alloc_op(input logic [DATA_W-1:0] size);
    send_heap_op(REQ_ALLOC, size, $urandom, 2'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic free_op(input logic [DATA_W-1:0] addr);
    send_heap_op(REQ_FREE, $urandom, addr, 2'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic access_op(input req_t kind, input logic [DATA_W-1:0] addr,
                           input logic [1:0] aw, input logic sx,
                           input logic [DATA_W-1:0] data);
    send_heap_op(kind, $urandom, addr, aw, sx, data);
  endtask

  task automatic drain_responses();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_heap_base(input logic [DATA_W-1:0] value);
    drain_responses();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    heap_base   = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    bases_used++;
  endtask

  task automatic random_heap_op();
    int        pick, i, o;
    live_run_t r;
    logic [1:0] aw;
    pick = $urandom_range(99);
    if (live_runs.size() == 0 || pick < 25) begin
      alloc_op(random_size());
    end else if (pick < 42) begin
      i = $urandom_range(0, live_runs.size() - 1);
      r = live_runs[i];
      live_runs.delete(i);
      free_op(heap_base + r.off + $urandom_range(0, BANK_SZ - 1));
    end else if (pick < 93) begin
      r  = live_runs[$urandom_range(0, live_runs.size() - 1)];
      o  = $urandom_range(0, r.banks * BANK_SZ - 1);
      aw = ($urandom_range(15) == 0) ? AW_BAD : 2'($urandom_range(0, 2));
      access_op($urandom_range(1) ? REQ_LOAD : REQ_STORE, heap_base + r.off + o, aw,
                1'($urandom), $urandom);
    end else begin
      send_heap_op(req_t'($urandom_range(0, 3)), $urandom,
                   $urandom_range(1) ? $urandom : heap_base + $urandom_range(0, HEAP_BYTES + 7),
                   2'($urandom_range(0, 3)), 1'($urandom), $urandom);
    end
  endtask

  // empty the heap, take all of it in one run, then probe the window end
  task automatic full_heap_check();
    live_run_t r;
    drain_responses();
    while (live_runs.size() > 0) begin
      r = live_runs.pop_front();
      free_op(heap_base + r.off);
    end
    drain_responses();
    live_runs.delete();
    alloc_op(HEAP_BYTES);
    access_op(REQ_STORE, heap_base + HEAP_BYTES - 4, AW_WORD, 1'b0, 32'hF1E2_D3C4);
    access_op(REQ_LOAD,  heap_base + HEAP_BYTES - 4, AW_WORD, 1'b1, '0);
    access_op(REQ_LOAD,  heap_base + HEAP_BYTES - 1, AW_BYTE, 1'b1, '0);
    access_op(REQ_LOAD,  heap_base + HEAP_BYTES - 1, AW_HALF, 1'b0, '0);
    access_op(REQ_LOAD,  heap_base + HEAP_BYTES - 2, AW_WORD, 1'b0, '0);
    access_op(REQ_STORE, heap_base + HEAP_BYTES,     AW_BYTE, 1'b0, 32'hFF);
    alloc_op(32'd0);
    free_op(heap_base + HEAP_BYTES - 1);
    free_op(heap_base + BANK_SZ - 1);
    drain_responses();
    live_runs.delete();
  endtask

  task automatic directed_ops();
    logic [DATA_W-1:0] b;
    b = heap_base;
    access_op(REQ_LOAD, b, AW_WORD, 1'b0, '0);
    alloc_op(32'd0);
    alloc_op(32'd1);
    alloc_op(32'd64);
    alloc_op(32'd65);
    access_op(REQ_STORE, b,      AW_WORD, 1'b0, 32'h80FF_7F81);
    access_op(REQ_LOAD,  b,      AW_BYTE, 1'b1, '0);
    access_op(REQ_LOAD,  b,      AW_BYTE, 1'b0, '0);
    access_op(REQ_LOAD,  b + 2,  AW_HALF, 1'b1, '0);
    access_op(REQ_LOAD,  b + 2,  AW_HALF, 1'b0, '0);
    access_op(REQ_LOAD,  b,      AW_WORD, 1'b1, '0);
    access_op(REQ_STORE, b + 63, AW_HALF, 1'b0, 32'h1234_A5C3);
    access_op(REQ_LOAD,  b + 62, AW_WORD, 1'b0, '0);
    access_op(REQ_LOAD,  b,      AW_BAD,  1'b0, '0);
    access_op(REQ_STORE, b,      AW_BAD,  1'b0, 32'hFFFF_FFFF);
    free_op(b + 5);
    free_op(b);
    free_op(b + 4 * BANK_SZ);
    access_op(REQ_LOAD, b, AW_BYTE, 1'b0, '0);
    alloc_op(32'hFFFF_FFFF);
    alloc_op(HEAP_BYTES + 1);
    free_op(b - 1);
    alloc_op(32'd1);
    access_op(REQ_LOAD,  b, AW_WORD, 1'b0, '0);
    access_op(REQ_STORE, b + 5 * BANK_SZ - 1, AW_BYTE, 1'b0, 32'hFFFF_FF9E);
    access_op(REQ_LOAD,  b + 5 * BANK_SZ - 1, AW_BYTE, 1'b1, '0);
  endtask

  task automatic random_phase(input int calm_from, input int calm_to);
    for (int n = 0; n < PHASE_OPS; n++) begin
      calm = (n >= calm_from && n < calm_to);
      random_heap_op();
    end
    calm = 1'b0;
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_ALLOC;
    req_ch.alloc_bytes  = '0;
    req_ch.address      = '0;
    req_ch.access_width = AW_BYTE;
    req_ch.sign_extend  = 1'b0;
    req_ch.store_data   = '0;
    rsp_ch.ready        = 1'b0;
    foreach (sent_by_kind[k]) sent_by_kind[k] = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    directed_ops();
    random_phase(0, 0);
    write_heap_base(32'h0000_0000);
    random_phase(50, 350);
    write_heap_base(32'hFFFF_F000);
    full_heap_check();
    random_phase(0, 0);
    write_heap_base($urandom);
    random_phase(0, 0);
    write_heap_base(32'hFFFF_FFFF);
    random_phase(0, 0);

    drain_responses();
    repeat (40) @(negedge clk);
    $display("sent %0d words (alloc %0d, free %0d, load %0d, store %0d) over %0d heap bases",
             sent_by_kind[REQ_ALLOC] + sent_by_kind[REQ_FREE] + sent_by_kind[REQ_LOAD]
               + sent_by_kind[REQ_STORE], sent_by_kind[REQ_ALLOC], sent_by_kind[REQ_FREE],
             sent_by_kind[REQ_LOAD], sent_by_kind[REQ_STORE], bases_used);
    $display("checked %0d responses: %0d no-space, %0d illegal, %0d failures",
             checked, nospace_seen, illegal_seen, fails);
    if (fails == 0)
      $display("[heap_bank_allocator] OK");
    else
      $display("[heap_bank_allocator] ERROR");
    $finish;
  end

endmodule

### heap_bank_allocator.f
rtl/hba_pkg.sv
rtl/hba_req_if.sv
rtl/hba_rsp_if.sv
rtl/hba_ram.sv
rtl/heap_bank_allocator.sv
sim/heap_bank_checker.sv
sim/heap_bank_allocator_tb.sv
